// ===== sv/assert_macros.svh =====
// Assertion macros shared by the point table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition is never true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/ptdn_pkg.sv =====
// Shared types, constants and result codes of the point table.
`default_nettype none

package ptdn_pkg;

    localparam int DEPTH_DEFAULT   = 256;
    localparam int COORD_W_DEFAULT = 16;
    localparam int RADIUS_W        = 16;
    localparam int INDEX_W         = 8;
    localparam int REFS_W          = 8;
    localparam int STATUS_W        = 2;
    localparam int MAG_W           = 33;
    localparam int SQ_W            = 2 * RADIUS_W;
    localparam int DIST_W          = SQ_W + 1;
    localparam int OUT_DATA_W      = INDEX_W + REFS_W;

    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_FIND = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_EXISTING = 2'd0,
        ST_ADDED    = 2'd1,
        ST_NONE     = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic pipe_busy;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/ptdn_datapath.sv =====
// Datapath: point memory, scan pipeline, best-match tracking and result register.
`default_nettype none
`include "assert_macros.svh"

module ptdn_datapath
    import ptdn_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT,
    parameter int COORD_WIDTH = COORD_W_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dp_cmd_t              cmd,
    output      dp_status_t           status,
    input  wire logic [((2*COORD_WIDTH+RADIUS_W+7)/8)*8-1:0] s_tdata,
    input  wire logic                 s_tuser,
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    output      logic [OUT_DATA_W-1:0] m_tdata,
    output      logic [STATUS_W-1:0]  m_tuser
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_W = 2 * COORD_WIDTH + REFS_W;

    logic [COORD_WIDTH-1:0] in_x;
    logic [COORD_WIDTH-1:0] in_y;
    logic [RADIUS_W-1:0]    in_r;

    logic                   mode_reg;
    logic [COORD_WIDTH-1:0] qx_reg;
    logic [COORD_WIDTH-1:0] qy_reg;
    logic [DIST_W-1:0]      best_reg;
    logic                   found_reg;
    logic [IDX_W-1:0]       hit_idx_reg;
    logic [REFS_W-1:0]      hit_refs_reg;
    logic [CNT_W-1:0]       addr_reg;
    logic [CNT_W-1:0]       next_free_reg;

    logic [WORD_W-1:0]      mem [TABLE_DEPTH];
    logic [WORD_W-1:0]      rd_data_reg;

    logic                   v1_reg;
    logic [IDX_W-1:0]       idx1_reg;

    logic                   v2_reg;
    logic [IDX_W-1:0]       idx2_reg;
    logic                   eq2_reg;
    logic                   big2_reg;
    logic [RADIUS_W-1:0]    magx2_reg;
    logic [RADIUS_W-1:0]    magy2_reg;
    logic [REFS_W-1:0]      refs2_reg;

    logic                   v3_reg;
    logic [IDX_W-1:0]       idx3_reg;
    logic                   eq3_reg;
    logic                   big3_reg;
    logic [SQ_W-1:0]        sqx3_reg;
    logic [SQ_W-1:0]        sqy3_reg;
    logic [REFS_W-1:0]      refs3_reg;

    logic                   out_valid_reg;
    logic [INDEX_W-1:0]     out_idx_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [REFS_W-1:0]      out_refs_reg;

    logic [COORD_WIDTH-1:0] rd_x;
    logic [COORD_WIDTH-1:0] rd_y;
    logic [REFS_W-1:0]      rd_refs;
    logic [COORD_WIDTH:0]   dx;
    logic [COORD_WIDTH:0]   dy;
    logic [COORD_WIDTH:0]   magx;
    logic [COORD_WIDTH:0]   magy;
    logic [MAG_W-1:0]       magx_ext;
    logic [MAG_W-1:0]       magy_ext;
    logic [DIST_W-1:0]      dist_sum;
    logic                   take;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [WORD_W-1:0]      wr_data;
    logic                   bump;
    logic [IDX_W-1:0]       res_idx;
    status_t                res_status;
    logic [REFS_W-1:0]      res_refs;
    logic [REFS_W-1:0]      refs_inc;

    assign in_x = s_tdata[COORD_WIDTH-1:0];
    assign in_y = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign in_r = s_tdata[2*COORD_WIDTH+RADIUS_W-1:2*COORD_WIDTH];

    assign rd_x    = rd_data_reg[COORD_WIDTH-1:0];
    assign rd_y    = rd_data_reg[2*COORD_WIDTH-1:COORD_WIDTH];
    assign rd_refs = rd_data_reg[WORD_W-1:2*COORD_WIDTH];

    // Differences are formed one bit wider so that the magnitude always fits.
    assign dx   = {rd_x[COORD_WIDTH-1], rd_x} - {qx_reg[COORD_WIDTH-1], qx_reg};
    assign dy   = {rd_y[COORD_WIDTH-1], rd_y} - {qy_reg[COORD_WIDTH-1], qy_reg};
    assign magx = dx[COORD_WIDTH] ? (~dx + 1'b1) : dx;
    assign magy = dy[COORD_WIDTH] ? (~dy + 1'b1) : dy;
    assign magx_ext = MAG_W'(magx);
    assign magy_ext = MAG_W'(magy);

    assign dist_sum = DIST_W'(sqx3_reg) + DIST_W'(sqy3_reg);

    // A magnitude of 2^16 or more squares past any radius squared, so it never wins.
    always_comb
    begin
        if (mode_reg == ACT_FIND)
        begin
            take = v3_reg && !big3_reg && (dist_sum < best_reg);
        end
        else
        begin
            take = v3_reg && eq3_reg && !found_reg;
        end
    end

    assign refs_inc = (hit_refs_reg == REFS_MAX) ? hit_refs_reg : hit_refs_reg + 1'b1;

    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = hit_idx_reg;
        wr_data    = {refs_inc, qy_reg, qx_reg};
        bump       = 1'b0;
        res_idx    = '0;
        res_status = ST_NONE;
        res_refs   = '0;
        if (mode_reg == ACT_ADD)
        begin
            if (found_reg)
            begin
                wr_en      = cmd.commit;
                res_idx    = hit_idx_reg;
                res_status = ST_EXISTING;
                res_refs   = refs_inc;
            end
            else if (next_free_reg < CNT_W'(TABLE_DEPTH))
            begin
                wr_en      = cmd.commit;
                wr_addr    = next_free_reg[IDX_W-1:0];
                wr_data    = {REFS_W'(1), qy_reg, qx_reg};
                bump       = cmd.commit;
                res_idx    = next_free_reg[IDX_W-1:0];
                res_status = ST_ADDED;
                res_refs   = REFS_W'(1);
            end
            else
            begin
                res_status = ST_FULL;
            end
        end
        else if (found_reg)
        begin
            res_idx    = hit_idx_reg;
            res_status = ST_EXISTING;
            res_refs   = hit_refs_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            next_free_reg <= '0;
            found_reg     <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.load)
            begin
                addr_reg  <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    addr_reg <= addr_reg + 1'b1;
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (bump)
            begin
                next_free_reg <= next_free_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= s_tuser;
            qx_reg   <= in_x;
            qy_reg   <= in_y;
            best_reg <= DIST_W'(SQ_W'(in_r) * SQ_W'(in_r));
        end
        else if (take)
        begin
            best_reg     <= dist_sum;
            hit_idx_reg  <= idx3_reg;
            hit_refs_reg <= refs3_reg;
        end

        idx1_reg  <= addr_reg[IDX_W-1:0];

        idx2_reg  <= idx1_reg;
        eq2_reg   <= (rd_x == qx_reg) && (rd_y == qy_reg);
        big2_reg  <= |magx_ext[MAG_W-1:RADIUS_W] || |magy_ext[MAG_W-1:RADIUS_W];
        magx2_reg <= magx_ext[RADIUS_W-1:0];
        magy2_reg <= magy_ext[RADIUS_W-1:0];
        refs2_reg <= rd_refs;

        idx3_reg  <= idx2_reg;
        eq3_reg   <= eq2_reg;
        big3_reg  <= big2_reg;
        sqx3_reg  <= SQ_W'(magx2_reg) * SQ_W'(magx2_reg);
        sqy3_reg  <= SQ_W'(magy2_reg) * SQ_W'(magy2_reg);
        refs3_reg <= refs2_reg;

        if (cmd.commit)
        begin
            out_idx_reg    <= INDEX_W'(res_idx);
            out_status_reg <= res_status;
            out_refs_reg   <= res_refs;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[addr_reg[IDX_W-1:0]];
        end
    end

    assign status.scan_end  = (addr_reg == next_free_reg);
    assign status.pipe_busy = v1_reg || v2_reg || v3_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_refs_reg, out_idx_reg};
    assign m_tuser  = out_status_reg;

    `ASSERT_NEVER(a_free_bound, clk, rst_n, next_free_reg > CNT_W'(TABLE_DEPTH), "fill count past depth")
    `ASSERT_AT(a_issue_stored, clk, rst_n, cmd.issue |-> (addr_reg < next_free_reg), "read beyond fill")

endmodule

`default_nettype wire

// ===== sv/ptdn_ctrl.sv =====
// Controller: sequences accept, scan, pipeline drain and result commit.
`default_nettype none
`include "assert_macros.svh"

module ptdn_ctrl
    import ptdn_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output      logic       s_tready,
    input  wire dp_status_t status,
    output      dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   tready_reg;

    always_comb
    begin
        cmd.load   = (state_reg == S_IDLE) && tready_reg && s_tvalid;
        cmd.issue  = (state_reg == S_SCAN) && !status.scan_end;
        cmd.commit = (state_reg == S_FINISH) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tready_reg <= 1'b1;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.load)
                    begin
                        state_reg  <= S_SCAN;
                        tready_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    if (status.scan_end)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (!status.pipe_busy)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (status.out_free)
                    begin
                        state_reg  <= S_IDLE;
                        tready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg  <= S_IDLE;
                    tready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign s_tready = tready_reg;

    `ASSERT_AT(a_ready_idle, clk, rst_n, tready_reg |-> (state_reg == S_IDLE), "ready while busy")
    `ASSERT_AT(a_commit_drained, clk, rst_n, cmd.commit |-> !status.pipe_busy, "commit before drain")

endmodule

`default_nettype wire

// ===== sv/point_table_dedup_nearest.sv =====
// Top level of the deduplicating point table with nearest-point search.
//
// Channel   Dir  Bits   Content
// s_tdata   in   48     point_x, point_y, search_radius
// s_tuser   in   1      action
// m_tdata   out  16     entry_index, ref_count
// m_tuser   out  2      status
//
// Each request is accepted, then the scan runs over the N stored points (up to TABLE_DEPTH),
// reading one memory word per cycle, and the three pipeline stages drain before the result
// is committed. The next beat is accepted only after the result has been loaded into the
// output register; s_tready rises at the same clock edge as the result is loaded.
// Reset clears the fill count and all handshake state; no clearing pass is needed.
// A result waits in the output register while m_tready is low, and a new beat is
// accepted meanwhile, but its result is held back until the register is free.
`default_nettype none

module point_table_dedup_nearest
    import ptdn_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT,
    parameter int COORD_WIDTH = COORD_W_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    // point_x, point_y, search_radius, zero padding
    input  wire logic [((2*COORD_WIDTH+RADIUS_W+7)/8)*8-1:0] s_tdata,
    // action
    input  wire logic                 s_tuser,
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    // entry_index, ref_count
    output      logic [OUT_DATA_W-1:0] m_tdata,
    // status
    output      logic [STATUS_W-1:0]  m_tuser
);

    dp_cmd_t    cmd;
    dp_status_t status;

    ptdn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ptdn_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
